@@ hdl/temn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge midnode numbering package
// Shared widths and constants for the edge table and its sequencer.
// ----------------------------------------------------------------------------
package temn_pkg;
  localparam int NodeIdBits   = 20;
  localparam int EdgeCapacity = 4096;
  localparam int SlotBits     = $clog2(EdgeCapacity);
  localparam int CountBits    = SlotBits + 1;
  localparam int KeyBits      = 2 * NodeIdBits;

  typedef logic [NodeIdBits-1:0] node_id_t;
  typedef logic [KeyBits-1:0]    edge_key_t;
  typedef logic [SlotBits-1:0]   slot_t;

  // Pair table, edge order 01 12 02 03 13 23.
  function automatic logic [1:0] pair_lo(input logic [2:0] e);
    case (e)
      3'd0: pair_lo = 2'd0;
      3'd1: pair_lo = 2'd1;
      3'd2: pair_lo = 2'd0;
      3'd3: pair_lo = 2'd0;
      3'd4: pair_lo = 2'd1;
      3'd5: pair_lo = 2'd2;
      default: pair_lo = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pair_hi(input logic [2:0] e);
    case (e)
      3'd0: pair_hi = 2'd1;
      3'd1: pair_hi = 2'd2;
      3'd2: pair_hi = 2'd2;
      3'd3: pair_hi = 2'd3;
      3'd4: pair_hi = 2'd3;
      3'd5: pair_hi = 2'd3;
      default: pair_hi = 2'd0;
    endcase
  endfunction
endpackage

@@ hdl/temn_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge key hash
// Slot index from a key, multiplicative hash split into four 16-bit partial products.
// ----------------------------------------------------------------------------
module temn_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  temn_pkg::edge_key_t key_i,
  output logic                done_o,
  output temn_pkg::slot_t     slot_o
);
  import temn_pkg::*;

  localparam logic [63:0] Golden = 64'h9E3779B97F4A7C15;

  logic [63:0] key_q;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [15:0] digit;
  logic [63:0] part;
  logic [63:0] mixed;

  // one 16x64 partial product per cycle
  always_comb begin
    digit = key_q[16*step_q +: 16];
    part  = ({48'd0, digit} * Golden) << (16 * step_q);
    acc_d = acc_q + part;
  end

  assign mixed  = acc_q ^ (acc_q >> 29);
  assign slot_o = mixed[SlotBits-1:0];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= {{(64-KeyBits){1'b0}}, key_i};
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end
endmodule

@@ hdl/temn_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge table memory
// Key and node id store, one port, registered read.
// ----------------------------------------------------------------------------
module temn_table (
  input  logic                 clk_i,
  input  temn_pkg::slot_t      addr_i,
  input  logic                 we_i,
  input  temn_pkg::edge_key_t  wkey_i,
  input  temn_pkg::node_id_t   wnode_i,
  output temn_pkg::edge_key_t  rkey_o,
  output temn_pkg::node_id_t   rnode_o
);
  import temn_pkg::*;

  logic [KeyBits+NodeIdBits-1:0] mem_q [EdgeCapacity];
  logic [KeyBits+NodeIdBits-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= {wkey_i, wnode_i};
    rd_q <= mem_q[addr_i];
  end

  assign rkey_o  = rd_q[KeyBits+NodeIdBits-1:NodeIdBits];
  assign rnode_o = rd_q[NodeIdBits-1:0];
endmodule

@@ hdl/tetra_edge_midnode_numbering_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron edge midnode numbering unit
// Per edge the shared hash unit maps the key to a slot; then each probe of
//   the single-port table runs a read and a check state, until a hit, a free
//   slot or the probe limit. A final state posts the result, and busy drops
//   in the cycle that done_o rises. A new request is taken only in idle,
//   after the last one is done. Reset: a clearing pass over every slot,
//   busy high. The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module tetra_edge_midnode_numbering_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  temn_pkg::node_id_t  corner_0_i,
  input  temn_pkg::node_id_t  corner_1_i,
  input  temn_pkg::node_id_t  corner_2_i,
  input  temn_pkg::node_id_t  corner_3_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  temn_pkg::node_id_t  cfg_data_i,
  output logic                done_o,
  output temn_pkg::node_id_t  node_0_o,
  output temn_pkg::node_id_t  node_1_o,
  output temn_pkg::node_id_t  node_2_o,
  output temn_pkg::node_id_t  node_3_o,
  output temn_pkg::node_id_t  mid_01_o,
  output temn_pkg::node_id_t  mid_12_o,
  output temn_pkg::node_id_t  mid_02_o,
  output temn_pkg::node_id_t  mid_03_o,
  output temn_pkg::node_id_t  mid_13_o,
  output temn_pkg::node_id_t  mid_23_o,
  output logic                overflow_o
);
  import temn_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_DONE
  } state_e;

  state_e          state_q;
  node_id_t        corner_q [4];
  node_id_t        mid_q [6];
  logic            bad_q;
  logic [2:0]      edge_q;
  slot_t           slot_q;
  logic [CountBits-1:0] probe_q;
  logic [CountBits-1:0] count_q;
  node_id_t        next_q;
  logic            spent_q;
  logic            valid_q [EdgeCapacity];
  logic            vrd_q;
  logic            kick_q;
  logic            hstart;
  logic            hdone;
  slot_t           hslot;
  edge_key_t       key;
  node_id_t        a, b;
  logic            we;
  edge_key_t       rkey;
  node_id_t        rnode;
  slot_t           addr;

  assign a   = corner_q[pair_lo(edge_q)];
  assign b   = corner_q[pair_hi(edge_q)];
  assign key = (a < b) ? {a, b} : {b, a};

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  // hash starts in the first S_HASH cycle, once corners and edge are latched
  assign hstart      = kick_q;
  assign addr = slot_q;
  assign we   = (state_q == S_CHECK) && !vrd_q && count_q != CountBits'(EdgeCapacity)
                && !spent_q;

  temn_hash u_hash (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(hstart),
    .key_i(key), .done_o(hdone), .slot_o(hslot)
  );

  temn_table u_table (
    .clk_i(clk_i), .addr_i(addr), .we_i(we), .wkey_i(key), .wnode_i(next_q),
    .rkey_o(rkey), .rnode_o(rnode)
  );

  always_ff @(posedge clk_i) begin
    vrd_q <= valid_q[addr];
    if (state_q == S_CLEAR) valid_q[slot_q] <= 1'b0;
    else if (we) valid_q[addr] <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      slot_q  <= '0;
      count_q <= '0;
      next_q  <= '0;
      spent_q <= 1'b0;
      edge_q  <= '0;
      probe_q <= '0;
      bad_q   <= 1'b0;
      kick_q  <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      kick_q <= 1'b0;
      if (cfg_valid_i && count_q == '0) begin
        next_q  <= cfg_data_i;
        spent_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == slot_t'(EdgeCapacity - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            corner_q[0] <= corner_0_i;
            corner_q[1] <= corner_1_i;
            corner_q[2] <= corner_2_i;
            corner_q[3] <= corner_3_i;
            edge_q <= '0;
            bad_q  <= 1'b0;
            kick_q <= 1'b1;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          probe_q <= '0;
          if (hdone) begin
            slot_q  <= hslot;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_CHECK;
        S_CHECK: begin
          if (vrd_q && rkey != key) begin
            slot_q  <= slot_q + 1'b1;
            probe_q <= probe_q + 1'b1;
            if (probe_q == CountBits'(EdgeCapacity - 1)) begin
              mid_q[edge_q] <= '0;
              bad_q <= 1'b1;
              state_q <= (edge_q == 3'd5) ? S_DONE : S_HASH;
              kick_q <= (edge_q != 3'd5);
              edge_q <= edge_q + 3'd1;
            end else begin
              state_q <= S_READ;
            end
          end else begin
            if (vrd_q) begin
              mid_q[edge_q] <= rnode;
            end else if (we) begin
              mid_q[edge_q] <= next_q;
              count_q <= count_q + 1'b1;
              if (&next_q) spent_q <= 1'b1;
              else next_q <= next_q + 1'b1;
            end else begin
              mid_q[edge_q] <= '0;
              bad_q <= 1'b1;
            end
            edge_q  <= edge_q + 3'd1;
            state_q <= (edge_q == 3'd5) ? S_DONE : S_HASH;
            kick_q  <= (edge_q != 3'd5);
          end
        end
        S_DONE: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign node_0_o   = corner_q[0];
  assign node_1_o   = corner_q[1];
  assign node_2_o   = corner_q[2];
  assign node_3_o   = corner_q[3];
  assign mid_01_o   = mid_q[0];
  assign mid_12_o   = mid_q[1];
  assign mid_02_o   = mid_q[2];
  assign mid_03_o   = mid_q[3];
  assign mid_13_o   = mid_q[4];
  assign mid_23_o   = mid_q[5];
  assign overflow_o = bad_q;
endmodule
